[rtl/core/asm_pkg.sv]
`timescale 1ns / 1ps

package asm_pkg;

    // Field widths of one sample word and one result word
    localparam int RAW_W  = 16;
    localparam int MG_W   = 12;
    localparam int AXES   = 3;
    localparam int AXIS_W = 2;

    // Axis codes used to select the axis being worked on
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // Scale factor numerator: milli-g = raw * 61 / 1000
    localparam int MG_NUM = 61;
    localparam int PROD_W = 21;   // |raw| * 61 fits in 21 bits

    // Division by 1000 is a shift by 3 followed by division by 125,
    // done as a multiply by ceil(2^25 / 125) and a shift by 25.
    localparam int DIV_PRE_SHIFT = 3;
    localparam int QIN_W         = PROD_W - DIV_PRE_SHIFT;
    localparam int RECIP_W       = 19;
    localparam int RECIP_SHIFT   = 25;
    localparam logic [RECIP_W-1:0] RECIP_125 = 19'd268436;

    // Magnitude of one scaled axis and the squared sum
    localparam int Q_W   = 11;
    localparam int SQ_W  = 2 * Q_W;
    localparam int SUM_W = 24;
    localparam logic [Q_W-1:0] Q_MAX = 11'd1998;

    // Square root: one result bit per step
    localparam int ROOT_W  = 12;
    localparam int REM_W   = 14;
    localparam int STEP_W  = 4;
    localparam logic [STEP_W-1:0] ROOT_LAST = 4'(ROOT_W - 1);

    // Packed word widths on the stream ports
    localparam int IN_DATA_W  = AXES * RAW_W;
    localparam int OUT_DATA_W = 4 * MG_W;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load;
        logic              mul;
        logic              div;
        logic              sqr;
        logic              last;
        logic              root;
        logic              out_load;
        logic [AXIS_W-1:0] axis;
    } cmd_t;

endpackage

[rtl/core/asm_datapath.sv]
`timescale 1ns / 1ps

module asm_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  asm_pkg::cmd_t                       cmd,
    input  logic [asm_pkg::IN_DATA_W-1:0]       in_data,
    output logic [asm_pkg::OUT_DATA_W-1:0]      out_data
);

    // Sample and working registers
    logic signed [asm_pkg::RAW_W-1:0] raw_reg [asm_pkg::AXES];
    logic signed [asm_pkg::MG_W-1:0]  mg_reg  [asm_pkg::AXES];
    logic [asm_pkg::PROD_W-1:0]       prod_reg;
    logic                             neg_reg;
    logic [asm_pkg::Q_W-1:0]          q_reg;
    logic [asm_pkg::SUM_W-1:0]        sum_reg;
    logic [asm_pkg::SUM_W-1:0]        rad_reg;
    logic [asm_pkg::REM_W-1:0]        rem_reg;
    logic [asm_pkg::ROOT_W-1:0]       root_reg;
    logic [asm_pkg::OUT_DATA_W-1:0]   out_reg;

    logic signed [asm_pkg::RAW_W-1:0]          raw_sel;
    logic [asm_pkg::RAW_W:0]                   abs_raw;
    logic [asm_pkg::PROD_W+1:0]                mul_full;
    logic [asm_pkg::QIN_W+asm_pkg::RECIP_W-1:0] recip_full;
    logic [asm_pkg::Q_W-1:0]                   q_next;
    logic [asm_pkg::SQ_W-1:0]                  sq;
    logic [asm_pkg::SUM_W-1:0]                 sum_next;
    logic [asm_pkg::REM_W+1:0]                 rem_sh;
    logic [asm_pkg::REM_W+1:0]                 trial;
    logic [asm_pkg::REM_W+1:0]                 rem_diff;
    logic                                      bit_set;

    // Select the axis being worked on and take its absolute value
    always_comb
    begin
        case (cmd.axis)
            asm_pkg::AXIS_X: raw_sel = raw_reg[0];
            asm_pkg::AXIS_Y: raw_sel = raw_reg[1];
            asm_pkg::AXIS_Z: raw_sel = raw_reg[2];
            default:         raw_sel = raw_reg[0];
        endcase
        abs_raw = raw_sel[asm_pkg::RAW_W-1]
                ? (~{raw_sel[asm_pkg::RAW_W-1], raw_sel} + 1'b1)
                : {1'b0, raw_sel};
    end

    // Scale by 61, then divide by 1000 through the reciprocal of 125
    assign mul_full   = abs_raw * 6'(asm_pkg::MG_NUM);
    assign recip_full = prod_reg[asm_pkg::PROD_W-1:asm_pkg::DIV_PRE_SHIFT]
                      * asm_pkg::RECIP_125;
    assign q_next     = recip_full[asm_pkg::RECIP_SHIFT+asm_pkg::Q_W-1:asm_pkg::RECIP_SHIFT];

    // Square and accumulate one axis
    assign sq       = q_reg * q_reg;
    assign sum_next = sum_reg + asm_pkg::SUM_W'(sq);

    // One step of the digit-by-digit square root
    assign rem_sh   = {rem_reg, rad_reg[asm_pkg::SUM_W-1:asm_pkg::SUM_W-2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign rem_diff = rem_sh - trial;
    assign bit_set  = (rem_sh >= trial);

    // Sample capture and per-axis scaling
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg[0] <= in_data[asm_pkg::RAW_W-1:0];
            raw_reg[1] <= in_data[2*asm_pkg::RAW_W-1:asm_pkg::RAW_W];
            raw_reg[2] <= in_data[3*asm_pkg::RAW_W-1:2*asm_pkg::RAW_W];
        end
        if (cmd.mul)
        begin
            prod_reg <= mul_full[asm_pkg::PROD_W-1:0];
            neg_reg  <= raw_sel[asm_pkg::RAW_W-1];
        end
        if (cmd.div)
        begin
            q_reg <= q_next;
            case (cmd.axis)
                asm_pkg::AXIS_X: mg_reg[0] <= neg_reg ? -{1'b0, q_next} : {1'b0, q_next};
                asm_pkg::AXIS_Y: mg_reg[1] <= neg_reg ? -{1'b0, q_next} : {1'b0, q_next};
                asm_pkg::AXIS_Z: mg_reg[2] <= neg_reg ? -{1'b0, q_next} : {1'b0, q_next};
                default:         mg_reg[0] <= neg_reg ? -{1'b0, q_next} : {1'b0, q_next};
            endcase
        end
    end

    // Sum of squares and square root iteration
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sqr)
        begin
            sum_reg <= sum_next;
        end

        if (cmd.sqr && cmd.last)
        begin
            rad_reg  <= sum_next;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root)
        begin
            rad_reg  <= {rad_reg[asm_pkg::SUM_W-3:0], 2'b00};
            rem_reg  <= bit_set ? rem_diff[asm_pkg::REM_W-1:0] : rem_sh[asm_pkg::REM_W-1:0];
            root_reg <= {root_reg[asm_pkg::ROOT_W-2:0], bit_set};
        end
    end

    // Result word, held while it waits on the output side
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= {root_reg, mg_reg[2], mg_reg[1], mg_reg[0]};
        end
    end

    assign out_data = out_reg;

`ifndef ASSERT_OFF
    // A scaled axis never exceeds full scale of the sensor range
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div |=> (q_reg <= asm_pkg::Q_MAX))
        else $error("scaled axis out of range");

    // The square root remainder stays within twice the partial root
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.root |=> ({2'b00, rem_reg} <= {1'b0, root_reg, 1'b0}))
        else $error("square root remainder too large");
`endif

endmodule

[rtl/core/asm_ctrl.sv]
`timescale 1ns / 1ps

module asm_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output asm_pkg::cmd_t cmd
);

    // State codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SQR  = 3'd3;
    localparam logic [2:0] ST_ROOT = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [asm_pkg::AXIS_W-1:0]  axis_reg, axis_next;
    logic [asm_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;

    // Sequencer: three passes of scale and square, then the root steps
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.axis       = axis_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = asm_pkg::AXIS_X;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                cmd.sqr = 1'b1;
                if (axis_reg == asm_pkg::AXIS_Z)
                begin
                    cmd.last   = 1'b1;
                    step_next  = '0;
                    state_next = ST_ROOT;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_ROOT:
            begin
                cmd.root  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == asm_pkg::ROOT_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= asm_pkg::AXIS_X;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;

`ifndef ASSERT_OFF
    // An accepted sample always starts the scaling of the X axis
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_MUL && axis_reg == asm_pkg::AXIS_X))
        else $error("sample accepted without starting X axis");

    // The axis counter never leaves the three axes
    assert property (@(posedge clk) disable iff (!rst_n)
        (axis_reg == asm_pkg::AXIS_X || axis_reg == asm_pkg::AXIS_Y ||
         axis_reg == asm_pkg::AXIS_Z))
        else $error("axis counter out of range");

    // A result is only loaded when the output slot is free or being taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("result word overwritten");

    // The root sequence takes exactly as many steps as result bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT) |-> (step_reg <= asm_pkg::ROOT_LAST))
        else $error("square root step count overrun");
`endif

endmodule

[rtl/core/accel_scale_and_magnitude.sv]
`timescale 1ns / 1ps

// Channel   Direction  Word
// s_axis    in         tdata[47:0]: raw_x, raw_y, raw_z (16 bits signed each)
// m_axis    out        tdata[47:0]: x_mg, y_mg, z_mg (12 bits signed), magnitude_mg (12 bits)
//
// A sample is accepted in the idle state; each axis in turn is then scaled by 61, divided
// by 1000 through the reciprocal and squared into the sum; then twelve steps of the
// bit-serial square root give one result bit per cycle, and the result word is loaded.
// A new sample is accepted once the previous result has moved to the output register, so
// only the result after a stalled one waits, and the input stalls until that one can load.
// Reset is asynchronous and clears the sequencer and the output valid flag.

module accel_scale_and_magnitude
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // raw_x [15:0], raw_y [31:16], raw_z [47:32]
    input  logic [asm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // x_mg [11:0], y_mg [23:12], z_mg [35:24], magnitude_mg [47:36]
    output logic [asm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    asm_pkg::cmd_t cmd;

    // Sequencer
    asm_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    // Arithmetic
    asm_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata)
    );

endmodule
